[design/rid_pkg.sv]
// rid_pkg: instruction identifiers, opcode constants and field widths
// shared by the decode logic and the top level; no dependencies
package rid_pkg;

   localparam int unsigned IdWidth = 8;

   localparam logic [7:0] ID_ILLEGAL  = 8'd0;
   localparam logic [7:0] ID_LB       = 8'd1;
   localparam logic [7:0] ID_LH       = 8'd2;
   localparam logic [7:0] ID_LW       = 8'd3;
   localparam logic [7:0] ID_LD       = 8'd4;
   localparam logic [7:0] ID_LBU      = 8'd5;
   localparam logic [7:0] ID_LHU      = 8'd6;
   localparam logic [7:0] ID_LWU      = 8'd7;
   localparam logic [7:0] ID_FLW      = 8'd8;
   localparam logic [7:0] ID_FLD      = 8'd9;
   localparam logic [7:0] ID_FSW      = 8'd10;
   localparam logic [7:0] ID_FSD      = 8'd11;
   localparam logic [7:0] ID_FMADD_S  = 8'd12;
   localparam logic [7:0] ID_FENCE    = 8'd20;
   localparam logic [7:0] ID_FENCE_I  = 8'd21;
   localparam logic [7:0] ID_ADDI     = 8'd22;
   localparam logic [7:0] ID_SLLI     = 8'd23;
   localparam logic [7:0] ID_SLOI     = 8'd24;
   localparam logic [7:0] ID_SBSETI   = 8'd25;
   localparam logic [7:0] ID_REV8     = 8'd26;
   localparam logic [7:0] ID_REV      = 8'd27;
   localparam logic [7:0] ID_SBCLRI   = 8'd28;
   localparam logic [7:0] ID_CLZ      = 8'd29;
   localparam logic [7:0] ID_CTZ      = 8'd30;
   localparam logic [7:0] ID_PCNT     = 8'd31;
   localparam logic [7:0] ID_SBINVI   = 8'd32;
   localparam logic [7:0] ID_SLTI     = 8'd33;
   localparam logic [7:0] ID_SLTIU    = 8'd34;
   localparam logic [7:0] ID_XORI     = 8'd35;
   localparam logic [7:0] ID_SRLI     = 8'd36;
   localparam logic [7:0] ID_SROI     = 8'd37;
   localparam logic [7:0] ID_ORC_B    = 8'd38;
   localparam logic [7:0] ID_SRAI     = 8'd39;
   localparam logic [7:0] ID_SBEXTI   = 8'd40;
   localparam logic [7:0] ID_RORI     = 8'd41;
   localparam logic [7:0] ID_ORI      = 8'd42;
   localparam logic [7:0] ID_ANDI     = 8'd43;
   localparam logic [7:0] ID_AUIPC    = 8'd44;
   localparam logic [7:0] ID_ADDIW    = 8'd45;
   localparam logic [7:0] ID_SLLIW    = 8'd46;
   localparam logic [7:0] ID_SRLIW    = 8'd47;
   localparam logic [7:0] ID_SRAIW    = 8'd48;
   localparam logic [7:0] ID_SB       = 8'd49;
   localparam logic [7:0] ID_SH       = 8'd50;
   localparam logic [7:0] ID_SW       = 8'd51;
   localparam logic [7:0] ID_AMO_W    = 8'd52;
   localparam logic [7:0] ID_AMO_D    = 8'd63;
   localparam logic [7:0] ID_ADD      = 8'd74;
   localparam logic [7:0] ID_SLL      = 8'd75;
   localparam logic [7:0] ID_SLT      = 8'd76;
   localparam logic [7:0] ID_SLTU     = 8'd77;
   localparam logic [7:0] ID_XOR      = 8'd78;
   localparam logic [7:0] ID_SRL      = 8'd79;
   localparam logic [7:0] ID_OR       = 8'd80;
   localparam logic [7:0] ID_AND      = 8'd81;
   localparam logic [7:0] ID_MUL      = 8'd82;
   localparam logic [7:0] ID_MULH     = 8'd83;
   localparam logic [7:0] ID_MULHSU   = 8'd84;
   localparam logic [7:0] ID_MULHU    = 8'd85;
   localparam logic [7:0] ID_DIV      = 8'd86;
   localparam logic [7:0] ID_DIVU     = 8'd87;
   localparam logic [7:0] ID_REM      = 8'd88;
   localparam logic [7:0] ID_REMU     = 8'd89;
   localparam logic [7:0] ID_PACK     = 8'd90;
   localparam logic [7:0] ID_CLMUL    = 8'd91;
   localparam logic [7:0] ID_CLMULR   = 8'd92;
   localparam logic [7:0] ID_CLMULH   = 8'd93;
   localparam logic [7:0] ID_MIN      = 8'd94;
   localparam logic [7:0] ID_MAX      = 8'd95;
   localparam logic [7:0] ID_MINU     = 8'd96;
   localparam logic [7:0] ID_MAXU     = 8'd97;
   localparam logic [7:0] ID_SLO      = 8'd98;
   localparam logic [7:0] ID_SH1ADD   = 8'd99;
   localparam logic [7:0] ID_SH2ADD   = 8'd100;
   localparam logic [7:0] ID_SRO      = 8'd101;
   localparam logic [7:0] ID_SH3ADD   = 8'd102;
   localparam logic [7:0] ID_SBSET    = 8'd103;
   localparam logic [7:0] ID_SUB      = 8'd104;
   localparam logic [7:0] ID_XNOR     = 8'd105;
   localparam logic [7:0] ID_SRA      = 8'd106;
   localparam logic [7:0] ID_ORN      = 8'd107;
   localparam logic [7:0] ID_ANDN     = 8'd108;
   localparam logic [7:0] ID_SBCLR    = 8'd109;
   localparam logic [7:0] ID_SBEXT    = 8'd110;
   localparam logic [7:0] ID_ROL      = 8'd111;
   localparam logic [7:0] ID_ROR      = 8'd112;
   localparam logic [7:0] ID_SBINV    = 8'd113;
   localparam logic [7:0] ID_LUI      = 8'd114;
   localparam logic [7:0] ID_ADDW     = 8'd115;
   localparam logic [7:0] ID_SLLW     = 8'd116;
   localparam logic [7:0] ID_SRLW     = 8'd117;
   localparam logic [7:0] ID_MULW     = 8'd118;
   localparam logic [7:0] ID_DIVW     = 8'd119;
   localparam logic [7:0] ID_DIVUW    = 8'd120;
   localparam logic [7:0] ID_REMW     = 8'd121;
   localparam logic [7:0] ID_REMUW    = 8'd122;
   localparam logic [7:0] ID_SUBW     = 8'd123;
   localparam logic [7:0] ID_SRAW     = 8'd124;
   localparam logic [7:0] ID_BEQ      = 8'd125;
   localparam logic [7:0] ID_BNE      = 8'd126;
   localparam logic [7:0] ID_BLT      = 8'd127;
   localparam logic [7:0] ID_BGE      = 8'd128;
   localparam logic [7:0] ID_BLTU     = 8'd129;
   localparam logic [7:0] ID_BGEU     = 8'd130;
   localparam logic [7:0] ID_JALR     = 8'd131;
   localparam logic [7:0] ID_JAL      = 8'd132;
   localparam logic [7:0] ID_ECALL    = 8'd133;
   localparam logic [7:0] ID_EBREAK   = 8'd134;
   localparam logic [7:0] ID_URET     = 8'd135;
   localparam logic [7:0] ID_SRET     = 8'd136;
   localparam logic [7:0] ID_MRET     = 8'd137;
   localparam logic [7:0] ID_WFI      = 8'd138;
   localparam logic [7:0] ID_CSRRW    = 8'd139;
   localparam logic [7:0] ID_CSRRS    = 8'd140;
   localparam logic [7:0] ID_CSRRC    = 8'd141;
   localparam logic [7:0] ID_CSRRWI   = 8'd142;
   localparam logic [7:0] ID_CSRRSI   = 8'd143;
   localparam logic [7:0] ID_CSRRCI   = 8'd144;
   localparam logic [7:0] ID_LAST     = ID_CSRRCI;

   // major opcode groups, inst[6:2]
   localparam logic [4:0] OPC_LOAD     = 5'h00;
   localparam logic [4:0] OPC_LOAD_FP  = 5'h01;
   localparam logic [4:0] OPC_MISC_MEM = 5'h03;
   localparam logic [4:0] OPC_OP_IMM   = 5'h04;
   localparam logic [4:0] OPC_AUIPC    = 5'h05;
   localparam logic [4:0] OPC_OP_IMM32 = 5'h06;
   localparam logic [4:0] OPC_STORE    = 5'h08;
   localparam logic [4:0] OPC_STORE_FP = 5'h09;
   localparam logic [4:0] OPC_AMO      = 5'h0b;
   localparam logic [4:0] OPC_OP       = 5'h0c;
   localparam logic [4:0] OPC_LUI      = 5'h0d;
   localparam logic [4:0] OPC_OP32     = 5'h0e;
   localparam logic [4:0] OPC_MADD     = 5'h10;
   localparam logic [4:0] OPC_MSUB     = 5'h11;
   localparam logic [4:0] OPC_NMSUB    = 5'h12;
   localparam logic [4:0] OPC_NMADD    = 5'h13;
   localparam logic [4:0] OPC_BRANCH   = 5'h18;
   localparam logic [4:0] OPC_JALR     = 5'h19;
   localparam logic [4:0] OPC_JAL      = 5'h1b;
   localparam logic [4:0] OPC_SYSTEM   = 5'h1c;

   localparam logic [6:0] AMT_REV8   = 7'h18;
   localparam logic [6:0] AMT_REV    = 7'h1f;
   localparam logic [11:0] SYS_SRET  = 12'h102;
   localparam logic [11:0] SYS_MRET  = 12'h302;
   localparam logic [11:0] SYS_WFI   = 12'h105;

   typedef struct packed {
      logic [7:0]  id;
      logic [4:0]  op0;
      logic [31:0] op1;
      logic [31:0] op2;
      logic [4:0]  op3;
   } dec_type;

endpackage

[design/rid_decode.sv]
// rid_decode: combinational decode of one 32-bit instruction word
// depends on rid_pkg for identifiers, opcode constants and dec_type
module rid_decode
   import rid_pkg::*;
(
   input  logic [31:0] word,
   output dec_type     dec
);

   logic [4:0]  rd, rs1, rs2, top5;
   logic [2:0]  f3;
   logic [6:0]  f7, amt;
   logic [11:0] u12;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, sh6;
   logic [3:0]  amo_slot;
   logic [7:0]  id;
   dec_type     raw;

   assign rd    = word[11:7];
   assign f3    = word[14:12];
   assign rs1   = word[19:15];
   assign rs2   = word[24:20];
   assign f7    = word[31:25];
   assign top5  = word[31:27];
   assign u12   = word[31:20];
   assign amt   = word[26:20];
   assign sh6   = {26'd0, word[25:20]};
   assign imm_i = {{20{word[31]}}, word[31:20]};
   assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
   assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
   assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
   assign imm_u = {word[31:12], 12'd0};

   // atomics: the first five top codes, then every fourth
   always_comb begin
      if (top5 < 5'd5) amo_slot = 4'(top5);
      else if (top5[1:0] == 2'b00) amo_slot = 4'(top5[4:2]) + 4'd3;
      else amo_slot = 4'd15;
   end

   always_comb begin
      raw = '0;
      id  = ID_ILLEGAL;
      raw.op0 = rd;
      raw.op1 = {27'd0, rs1};
      raw.op2 = imm_i;
      unique case (word[6:2])
         OPC_LOAD: begin
            if (f3 != 3'd7) id = ID_LB + 8'(f3);
         end
         OPC_LOAD_FP: begin
            if (f3 == 3'd2) id = ID_FLW;
            else if (f3 == 3'd3) id = ID_FLD;
         end
         OPC_STORE_FP: begin
            raw.op0 = rs2;
            raw.op2 = imm_s;
            if (f3 == 3'd2) id = ID_FSW;
            else if (f3 == 3'd3) id = ID_FSD;
         end
         OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD: begin
            raw.op2 = {27'd0, rs2};
            raw.op3 = top5;
            if (!f7[1]) id = ID_FMADD_S + 8'({word[3:2], f7[0]});
         end
         OPC_MISC_MEM: begin
            raw.op2 = '0;
            raw.op1 = '0;
            if (rd == 5'd0 && rs1 == 5'd0) begin
               if (f3 == 3'd0 && word[31:28] == 4'd0) begin
                  raw.op0 = {1'b0, word[27:24]};
                  raw.op1 = {28'd0, word[23:20]};
                  id = ID_FENCE;
               end else if (f3 == 3'd1 && u12 == 12'd0) begin
                  id = ID_FENCE_I;
               end
            end
         end
         OPC_OP_IMM: begin
            priority if (f3 == 3'd1) begin
               unique case (top5)
                  5'h00: begin raw.op2 = {25'd0, amt}; id = ID_SLLI; end
                  5'h04: begin raw.op2 = {25'd0, amt}; id = ID_SLOI; end
                  5'h05: begin raw.op2 = {25'd0, amt}; id = ID_SBSETI; end
                  5'h08: begin
                     if (amt == AMT_REV8) id = ID_REV8;
                     else if (amt == AMT_REV) id = ID_REV;
                  end
                  5'h09: begin raw.op2 = {25'd0, amt}; id = ID_SBCLRI; end
                  5'h0c: begin
                     if (amt == 7'd0) id = ID_CLZ;
                     else if (amt == 7'd1) id = ID_CTZ;
                     else if (amt == 7'd2) id = ID_PCNT;
                  end
                  5'h0d: begin raw.op2 = {25'd0, amt}; id = ID_SBINVI; end
                  default: id = ID_ILLEGAL;
               endcase
            end else if (f3 == 3'd5) begin
               raw.op2 = {25'd0, amt};
               unique case (top5)
                  5'h00: id = ID_SRLI;
                  5'h04: id = ID_SROI;
                  5'h05: if (amt == AMT_REV8) id = ID_ORC_B;
                  5'h08: id = ID_SRAI;
                  5'h09: id = ID_SBEXTI;
                  5'h0c: id = ID_RORI;
                  default: id = ID_ILLEGAL;
               endcase
            end else begin
               unique case (f3)
                  3'd0: id = ID_ADDI;
                  3'd2: id = ID_SLTI;
                  3'd3: id = ID_SLTIU;
                  3'd4: id = ID_XORI;
                  3'd6: id = ID_ORI;
                  default: id = ID_ANDI;
               endcase
            end
         end
         OPC_AUIPC, OPC_LUI: begin
            raw.op1 = imm_u;
            raw.op2 = '0;
            id = word[5] ? ID_LUI : ID_AUIPC;
         end
         OPC_OP_IMM32: begin
            if (f3 == 3'd0) id = ID_ADDIW;
            else if (f3 == 3'd1 && f7 == 7'h00) begin
               raw.op2 = sh6; id = ID_SLLIW;
            end else if (f3 == 3'd5) begin
               raw.op2 = sh6;
               if (f7 == 7'h00) id = ID_SRLIW;
               else if (f7 == 7'h20) id = ID_SRAIW;
            end
         end
         OPC_STORE: begin
            raw.op0 = rs2;
            raw.op2 = imm_s;
            if (f3 < 3'd3) id = ID_SB + 8'(f3);
         end
         OPC_AMO: begin
            raw.op2 = {27'd0, rs2};
            if (amo_slot != 4'd15) begin
               if (f3 == 3'd2) id = ID_AMO_W + 8'(amo_slot);
               else if (f3 == 3'd3) id = ID_AMO_D + 8'(amo_slot);
            end
         end
         OPC_OP: begin
            raw.op2 = {27'd0, rs2};
            unique case (f7)
               7'h00: id = ID_ADD + 8'(f3);
               7'h01: id = ID_MUL + 8'(f3);
               7'h04: if (f3 == 3'd0) id = ID_PACK;
               7'h05: if (f3 != 3'd0) id = ID_CLMUL + 8'(f3 - 3'd1);
               7'h10: begin
                  unique case (f3)
                     3'd1: id = ID_SLO;
                     3'd2: id = ID_SH1ADD;
                     3'd4: id = ID_SH2ADD;
                     3'd5: id = ID_SRO;
                     3'd6: id = ID_SH3ADD;
                     default: id = ID_ILLEGAL;
                  endcase
               end
               7'h14: if (f3 == 3'd1) id = ID_SBSET;
               7'h20: begin
                  unique case (f3)
                     3'd0: id = ID_SUB;
                     3'd4: id = ID_XNOR;
                     3'd5: id = ID_SRA;
                     3'd6: id = ID_ORN;
                     3'd7: id = ID_ANDN;
                     default: id = ID_ILLEGAL;
                  endcase
               end
               7'h24: begin
                  if (f3 == 3'd1) id = ID_SBCLR;
                  else if (f3 == 3'd5) id = ID_SBEXT;
               end
               7'h30: begin
                  if (f3 == 3'd1) id = ID_ROL;
                  else if (f3 == 3'd5) id = ID_ROR;
               end
               7'h34: if (f3 == 3'd1) id = ID_SBINV;
               default: id = ID_ILLEGAL;
            endcase
         end
         OPC_OP32: begin
            raw.op2 = {27'd0, rs2};
            if (f7 == 7'h00) begin
               if (f3 == 3'd0) id = ID_ADDW;
               else if (f3 == 3'd1) id = ID_SLLW;
               else if (f3 == 3'd5) id = ID_SRLW;
            end else if (f7 == 7'h01) begin
               if (f3 == 3'd0) id = ID_MULW;
               else if (f3[2]) id = ID_DIVW + 8'(f3[1:0]);
            end else if (f7 == 7'h20) begin
               if (f3 == 3'd0) id = ID_SUBW;
               else if (f3 == 3'd5) id = ID_SRAW;
            end
         end
         OPC_BRANCH: begin
            raw.op0 = rs1;
            raw.op1 = {27'd0, rs2};
            raw.op2 = imm_b;
            if (f3 == 3'd0) id = ID_BEQ;
            else if (f3 == 3'd1) id = ID_BNE;
            else if (f3[2]) id = ID_BLT + 8'(f3[1:0]);
         end
         OPC_JALR: begin
            if (f3 == 3'd0) id = ID_JALR;
         end
         OPC_JAL: begin
            raw.op1 = imm_j;
            raw.op2 = '0;
            id = ID_JAL;
         end
         OPC_SYSTEM: begin
            raw.op2 = {20'd0, u12};
            if (f3 == 3'd0) begin
               if (f7 == 7'h00) begin
                  if (rd == 5'd0 && rs1 == 5'd0) begin
                     if (u12 == 12'd0) id = ID_ECALL;
                     else if (u12 == 12'd1) id = ID_EBREAK;
                     else if (u12 == 12'd2) id = ID_URET;
                  end
               end else if (f7 != 7'h09) begin
                  if (u12 == SYS_SRET) id = ID_SRET;
                  else if (u12 == SYS_MRET) id = ID_MRET;
                  else if (u12 == SYS_WFI) id = ID_WFI;
               end
            end else if (f3 != 3'd4) begin
               id = ID_CSRRW + 8'(f3[2] ? f3 - 3'd2 : f3 - 3'd1);
            end
         end
         default: id = ID_ILLEGAL;
      endcase
      raw.id = id;
   end

   // illegal words give all-zero operands
   always_comb begin
      if (word[1:0] != 2'b11 || raw.id == ID_ILLEGAL) dec = '0;
      else dec = raw;
   end

endmodule

[design/riscv_instruction_decoder_core.sv]
// riscv_instruction_decoder_core: top level of the instruction decoder
// holds the input register and result register; depends on rid_pkg and rid_decode
//
// usage:
//   req_ channel carries one 32-bit instruction word per transaction
//   rsp_ channel returns the instruction id (0 = illegal) and four operands
//   a word accepted into the input register is decoded into the result register
//   throughput: one transaction per cycle while rsp_ready is high, with the
//   decode logic between the input register and the result register
//   the two-stage pipe keeps flowing while rsp_ready is high; when the
//   receiver stalls, the result register holds, the input register fills,
//   and req_ready drops once both hold an item
//   reset clears both valid bits; no clearing pass, no configuration
//   the block keeps no state between words
module riscv_instruction_decoder_core
   import rid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instruction_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_instruction_id,
   output logic [4:0]  rsp_operand_zero,
   output logic [31:0] rsp_operand_one,
   output logic [31:0] rsp_operand_two,
   output logic [4:0]  rsp_operand_three
);

   logic        in_vld_ff, in_vld_in;
   logic [31:0] word_ff;
   logic        out_vld_ff, out_vld_in;
   dec_type     res_ff;
   dec_type     dec;
   logic        stage_move;

   rid_decode u_decode (
      .word (word_ff),
      .dec  (dec)
   );

   // input stage advances when the result register is empty or draining
   assign stage_move = !out_vld_ff || rsp_ready;
   assign req_ready  = !in_vld_ff || stage_move;
   assign in_vld_in  = (req_valid && req_ready) || (in_vld_ff && !stage_move);
   assign out_vld_in = stage_move ? in_vld_ff : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) word_ff <= req_instruction_word;
      if (stage_move && in_vld_ff) res_ff <= dec;
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_instruction_id = res_ff.id;
   assign rsp_operand_zero   = res_ff.op0;
   assign rsp_operand_one    = res_ff.op1;
   assign rsp_operand_two    = res_ff.op2;
   assign rsp_operand_three  = res_ff.op3;

   // a stalled result register must not be overwritten
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_ff))
      else $error("result changed while stalled");

   // an illegal id always carries zero operands
   a_illegal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_instruction_id == ID_ILLEGAL |->
         rsp_operand_zero == 5'd0 && rsp_operand_one == 32'd0 &&
         rsp_operand_two == 32'd0 && rsp_operand_three == 5'd0)
      else $error("illegal id with nonzero operands");

   // ids stay within the defined range
   a_id_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_instruction_id <= ID_LAST)
      else $error("instruction id out of range");

   // a full pipe refuses new words
   a_full: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && out_vld_ff && !rsp_ready |-> !req_ready)
      else $error("accepted word with pipe full");

endmodule

[bench/rid_decode_checker.sv]
`timescale 1ns / 1ps
// rid_decode_checker: watches the req_/rsp_ channels of the decoder, predicts
// each decode and compares it field by field; depends on rid_pkg
module rid_decode_checker
   import rid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_instruction_word,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_instruction_id,
   input  logic [4:0]  rsp_operand_zero,
   input  logic [31:0] rsp_operand_one,
   input  logic [31:0] rsp_operand_two,
   input  logic [4:0]  rsp_operand_three,
   output int          error_count,
   output int          decodes_pending
);

   dec_type expected_decodes[$];

   function automatic logic [7:0] amo_offset(input logic [4:0] t);
      case (t)
         5'h00: amo_offset = 8'd1;
         5'h01: amo_offset = 8'd2;
         5'h02: amo_offset = 8'd3;
         5'h03: amo_offset = 8'd4;
         5'h04: amo_offset = 8'd5;
         5'h08: amo_offset = 8'd6;
         5'h0c: amo_offset = 8'd7;
         5'h10: amo_offset = 8'd8;
         5'h14: amo_offset = 8'd9;
         5'h18: amo_offset = 8'd10;
         5'h1c: amo_offset = 8'd11;
         default: amo_offset = 8'd0;
      endcase
   endfunction

   function automatic dec_type decode_word(input logic [31:0] w);
      dec_type d;
      logic [4:0] rd, rs1, rs2, top5;
      logic [2:0] f3;
      logic [6:0] f7, amt;
      logic [11:0] u12;
      logic [31:0] imm_i, imm_s, imm_b, imm_j;
      rd = w[11:7]; rs1 = w[19:15]; rs2 = w[24:20]; f3 = w[14:12];
      f7 = w[31:25]; top5 = w[31:27]; u12 = w[31:20]; amt = w[26:20];
      imm_i = {{20{w[31]}}, w[31:20]};
      imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      d = '0;
      if (w[1:0] == 2'b11) begin
         case (w[6:2])
            OPC_LOAD: begin
               d.op0 = rd; d.op1 = {27'd0, rs1}; d.op2 = imm_i;
               case (f3)
                  3'd0: d.id = ID_LB;  3'd1: d.id = ID_LH;  3'd2: d.id = ID_LW;
                  3'd3: d.id = ID_LD;  3'd4: d.id = ID_LBU; 3'd5: d.id = ID_LHU;
                  3'd6: d.id = ID_LWU; default: d.id = ID_ILLEGAL;
               endcase
            end
            OPC_LOAD_FP: begin
               d.op0 = rd; d.op1 = {27'd0, rs1}; d.op2 = imm_i;
               d.id = f3 == 3'd2 ? ID_FLW : f3 == 3'd3 ? ID_FLD : ID_ILLEGAL;
            end
            OPC_STORE_FP: begin
               d.op0 = rs2; d.op1 = {27'd0, rs1}; d.op2 = imm_s;
               d.id = f3 == 3'd2 ? ID_FSW : f3 == 3'd3 ? ID_FSD : ID_ILLEGAL;
            end
            OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD: begin
               d.op0 = rd; d.op1 = {27'd0, rs1}; d.op2 = {27'd0, rs2}; d.op3 = top5;
               if (!f7[1])
                  d.id = ID_FMADD_S + 8'(2 * (w[6:2] - OPC_MADD)) + 8'(f7[0]);
            end
            OPC_MISC_MEM: begin
               if (rd == 0 && rs1 == 0) begin
                  if (f3 == 3'd0 && w[31:28] == 4'd0) begin
                     d.op0 = {1'b0, w[27:24]}; d.op1 = {28'd0, w[23:20]};
                     d.id = ID_FENCE;
                  end else if (f3 == 3'd1 && u12 == 12'd0) begin
                     d.id = ID_FENCE_I;
                  end
               end
            end
            OPC_OP_IMM: begin
               d.op0 = rd; d.op1 = {27'd0, rs1}; d.op2 = imm_i;
               if (f3 == 3'd1) begin
                  case (top5)
                     5'h00: begin d.op2 = {25'd0, amt}; d.id = ID_SLLI; end
                     5'h04: begin d.op2 = {25'd0, amt}; d.id = ID_SLOI; end
                     5'h05: begin d.op2 = {25'd0, amt}; d.id = ID_SBSETI; end
                     5'h08: d.id = amt == AMT_REV8 ? ID_REV8 : amt == AMT_REV ? ID_REV
                                 : ID_ILLEGAL;
                     5'h09: begin d.op2 = {25'd0, amt}; d.id = ID_SBCLRI; end
                     5'h0c: d.id = amt == 7'd0 ? ID_CLZ : amt == 7'd1 ? ID_CTZ
                                 : amt == 7'd2 ? ID_PCNT : ID_ILLEGAL;
                     5'h0d: begin d.op2 = {25'd0, amt}; d.id = ID_SBINVI; end
                     default: ;
                  endcase
               end else if (f3 == 3'd5) begin
                  d.op2 = {25'd0, amt};
                  case (top5)
                     5'h00: d.id = ID_SRLI;
                     5'h04: d.id = ID_SROI;
                     5'h05: d.id = amt == AMT_REV8 ? ID_ORC_B : ID_ILLEGAL;
                     5'h08: d.id = ID_SRAI;
                     5'h09: d.id = ID_SBEXTI;
                     5'h0c: d.id = ID_RORI;
                     default: ;
                  endcase
               end else begin
                  case (f3)
                     3'd0: d.id = ID_ADDI; 3'd2: d.id = ID_SLTI; 3'd3: d.id = ID_SLTIU;
                     3'd4: d.id = ID_XORI; 3'd6: d.id = ID_ORI;  default: d.id = ID_ANDI;
                  endcase
               end
            end
            OPC_AUIPC, OPC_LUI: begin
               d.op0 = rd; d.op1 = {w[31:12], 12'd0};
               d.id = w[6:2] == OPC_LUI ? ID_LUI : ID_AUIPC;
            end
            OPC_OP_IMM32: begin
               d.op0 = rd; d.op1 = {27'd0, rs1}; d.op2 = imm_i;
               if (f3 == 3'd0) d.id = ID_ADDIW;
               else if (f3 == 3'd1 && f7 == 7'd0) begin
                  d.op2 = {26'd0, w[25:20]}; d.id = ID_SLLIW;
               end else if (f3 == 3'd5) begin
                  d.op2 = {26'd0, w[25:20]};
                  d.id = f7 == 7'h00 ? ID_SRLIW : f7 == 7'h20 ? ID_SRAIW : ID_ILLEGAL;
               end
            end
            OPC_STORE: begin
               d.op0 = rs2; d.op1 = {27'd0, rs1}; d.op2 = imm_s;
               d.id = f3 == 3'd0 ? ID_SB : f3 == 3'd1 ? ID_SH : f3 == 3'd2 ? ID_SW
                    : ID_ILLEGAL;
            end
            OPC_AMO: begin
               d.op0 = rd; d.op1 = {27'd0, rs1}; d.op2 = {27'd0, rs2};
               if ((f3 == 3'd2 || f3 == 3'd3) && amo_offset(top5) != 0)
                  d.id = (f3 == 3'd2 ? ID_AMO_W : ID_AMO_D) + amo_offset(top5) - 8'd1;
            end
            OPC_OP: begin
               d.op0 = rd; d.op1 = {27'd0, rs1}; d.op2 = {27'd0, rs2};
               case (f7)
                  7'h00: d.id = ID_ADD + 8'(f3);
                  7'h01: d.id = ID_MUL + 8'(f3);
                  7'h04: d.id = f3 == 3'd0 ? ID_PACK : ID_ILLEGAL;
                  7'h05: d.id = f3 == 3'd0 ? ID_ILLEGAL : ID_CLMUL + 8'(f3) - 8'd1;
                  7'h10: case (f3)
                     3'd1: d.id = ID_SLO;    3'd2: d.id = ID_SH1ADD;
                     3'd4: d.id = ID_SH2ADD; 3'd5: d.id = ID_SRO;
                     3'd6: d.id = ID_SH3ADD; default: ;
                  endcase
                  7'h14: d.id = f3 == 3'd1 ? ID_SBSET : ID_ILLEGAL;
                  7'h20: case (f3)
                     3'd0: d.id = ID_SUB; 3'd4: d.id = ID_XNOR; 3'd5: d.id = ID_SRA;
                     3'd6: d.id = ID_ORN; 3'd7: d.id = ID_ANDN; default: ;
                  endcase
                  7'h24: d.id = f3 == 3'd1 ? ID_SBCLR : f3 == 3'd5 ? ID_SBEXT : ID_ILLEGAL;
                  7'h30: d.id = f3 == 3'd1 ? ID_ROL : f3 == 3'd5 ? ID_ROR : ID_ILLEGAL;
                  7'h34: d.id = f3 == 3'd1 ? ID_SBINV : ID_ILLEGAL;
                  default: ;
               endcase
            end
            OPC_OP32: begin
               d.op0 = rd; d.op1 = {27'd0, rs1}; d.op2 = {27'd0, rs2};
               if (f7 == 7'h00)
                  d.id = f3 == 3'd0 ? ID_ADDW : f3 == 3'd1 ? ID_SLLW
                       : f3 == 3'd5 ? ID_SRLW : ID_ILLEGAL;
               else if (f7 == 7'h01)
                  d.id = f3 == 3'd0 ? ID_MULW : f3 >= 3'd4 ? ID_DIVW + 8'(f3) - 8'd4
                       : ID_ILLEGAL;
               else if (f7 == 7'h20)
                  d.id = f3 == 3'd0 ? ID_SUBW : f3 == 3'd5 ? ID_SRAW : ID_ILLEGAL;
            end
            OPC_BRANCH: begin
               d.op0 = rs1; d.op1 = {27'd0, rs2}; d.op2 = imm_b;
               case (f3)
                  3'd0: d.id = ID_BEQ;  3'd1: d.id = ID_BNE;  3'd4: d.id = ID_BLT;
                  3'd5: d.id = ID_BGE;  3'd6: d.id = ID_BLTU; 3'd7: d.id = ID_BGEU;
                  default: ;
               endcase
            end
            OPC_JALR: begin
               d.op0 = rd; d.op1 = {27'd0, rs1}; d.op2 = imm_i;
               d.id = f3 == 3'd0 ? ID_JALR : ID_ILLEGAL;
            end
            OPC_JAL: begin
               d.op0 = rd; d.op1 = imm_j; d.id = ID_JAL;
            end
            OPC_SYSTEM: begin
               d.op0 = rd; d.op1 = {27'd0, rs1}; d.op2 = {20'd0, u12};
               if (f3 == 3'd0) begin
                  if (f7 == 7'd0) begin
                     if (rd == 0 && rs1 == 0)
                        d.id = u12 == 12'd0 ? ID_ECALL : u12 == 12'd1 ? ID_EBREAK
                             : u12 == 12'd2 ? ID_URET : ID_ILLEGAL;
                  end else if (f7 != 7'd9) begin
                     d.id = u12 == SYS_SRET ? ID_SRET : u12 == SYS_MRET ? ID_MRET
                          : u12 == SYS_WFI ? ID_WFI : ID_ILLEGAL;
                  end
               end else if (f3 != 3'd4) begin
                  d.id = ID_CSRRW + 8'(f3 > 3'd4 ? f3 - 3'd2 : f3 - 3'd1);
               end
            end
            default: ;
         endcase
      end
      if (d.id == ID_ILLEGAL) d = '0;
      return d;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      decodes_pending = 0;
   end

   always @(posedge clock) begin
      dec_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_decodes.size() == 0) begin
               report_mismatch("unexpected transaction", {24'd0, rsp_instruction_id},
                               32'd0);
            end else begin
               want = expected_decodes.pop_front();
               if (rsp_instruction_id !== want.id)
                  report_mismatch("instruction_id", {24'd0, rsp_instruction_id},
                                  {24'd0, want.id});
               if (rsp_operand_zero !== want.op0)
                  report_mismatch("operand_zero", {27'd0, rsp_operand_zero},
                                  {27'd0, want.op0});
               if (rsp_operand_one !== want.op1)
                  report_mismatch("operand_one", rsp_operand_one, want.op1);
               if (rsp_operand_two !== want.op2)
                  report_mismatch("operand_two", rsp_operand_two, want.op2);
               if (rsp_operand_three !== want.op3)
                  report_mismatch("operand_three", {27'd0, rsp_operand_three},
                                  {27'd0, want.op3});
            end
         end
         if (req_valid && req_ready)
            expected_decodes.push_back(decode_word(req_instruction_word));
         decodes_pending = expected_decodes.size();
      end
   end

endmodule

[bench/tb_riscv_instruction_decoder_core.sv]
`timescale 1ns / 1ps
// tb_riscv_instruction_decoder_core: drives instruction words into the decoder
// and gives the verdict; depends on rid_pkg, the decoder and rid_decode_checker
module tb_riscv_instruction_decoder_core
   import rid_pkg::*;
;

   localparam int RandomWords = 1700;
   localparam int CycleLimit  = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_instruction_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_instruction_id;
   logic [4:0]  rsp_operand_zero;
   logic [31:0] rsp_operand_one;
   logic [31:0] rsp_operand_two;
   logic [4:0]  rsp_operand_three;
   int          error_count;
   int          decodes_pending;
   int          cycle_count = 0;
   bit          quiet_tail = 1'b0;   // no idling in the last part of the run

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   riscv_instruction_decoder_core dut (.*);

   rid_decode_checker checker_i (.*);

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: random stall bursts between random runs of ready
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            stall = $urandom_range(1, 4);
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // present one word and hold it until the transaction completes
   task automatic send_word(input logic [31:0] w);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_instruction_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // random word biased toward legal groups: valid low bits and a real opcode
   function automatic logic [31:0] random_word();
      logic [31:0] w;
      logic [4:0] opcodes[20] = '{OPC_LOAD, OPC_LOAD_FP, OPC_MISC_MEM, OPC_OP_IMM,
         OPC_AUIPC, OPC_OP_IMM32, OPC_STORE, OPC_STORE_FP, OPC_AMO, OPC_OP, OPC_LUI,
         OPC_OP32, OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD, OPC_BRANCH, OPC_JALR,
         OPC_JAL, OPC_SYSTEM};
      w = $urandom;
      if ($urandom_range(0, 9) != 0) begin
         w[1:0] = 2'b11;
         w[6:2] = opcodes[$urandom_range(0, 19)];
         case ($urandom_range(0, 5))
            0: w[31:25] = 7'($urandom_range(0, 1) ? 7'h00 : 7'h20);
            1: w[31:25] = 7'($urandom_range(0, 'h34));
            2: begin       // system returns, fence, and bit-manip immediates
               w[31:20] = $urandom_range(0, 2) == 0 ? SYS_SRET
                        : $urandom_range(0, 1) ? SYS_MRET : SYS_WFI;
               if ($urandom_range(0, 1)) w[31:20] = 12'($urandom_range(0, 2));
               if ($urandom_range(0, 1)) w[19:7] = '0;
            end
            3: w[26:20] = $urandom_range(0, 1) ? AMT_REV8 : 7'($urandom_range(0, 2));
            4: w[31:27] = 5'(4 * $urandom_range(0, 7));
            default: ;
         endcase
      end
      return w;
   endfunction

   initial begin
      logic [31:0] directed[$];
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // extremes, the illegal group, fence forms, system returns, bit-manip cases
      directed = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0013, 32'hfff0_0013,
                   32'h8000_0003, 32'h0ff0_000f, 32'h1000_000f, 32'h0000_100f,
                   32'h0000_0073, 32'h0010_0073, 32'h0020_0073, 32'h1020_0073,
                   32'h3020_0073, 32'h1050_0073, 32'h12f7_8073, 32'h6980_1093,
                   32'h6180_5093, 32'h6020_1093, 32'h4020_5013, 32'hffff_f0b7,
                   32'h8000_006f, 32'hfe00_0ee3, 32'hffff_ffa7, 32'h0000_0053,
                   32'hf800_0043};
      foreach (directed[i]) send_word(directed[i]);
      for (int i = 0; i < RandomWords; i++) begin
         if (i == RandomWords - 200) quiet_tail = 1'b1;
         send_word(random_word());
      end
      req_valid <= 1'b0;

      while (decodes_pending != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
design/rid_pkg.sv
design/rid_decode.sv
design/riscv_instruction_decoder_core.sv
bench/rid_decode_checker.sv
bench/tb_riscv_instruction_decoder_core.sv
